### hw/rtl/olist_pkg.sv
// Shared types, request codes and status codes for the ordered list engine.
package olist_pkg;

  localparam int OL_CAPACITY   = 256;
  localparam int OL_DATA_WIDTH = 32;

  // request operation codes
  localparam logic [3:0] OP_INS_FRONT = 4'd0;
  localparam logic [3:0] OP_INS_LAST  = 4'd1;
  localparam logic [3:0] OP_INS_AT    = 4'd2;
  localparam logic [3:0] OP_INS_KEY   = 4'd3;
  localparam logic [3:0] OP_INS_SORT  = 4'd4;
  localparam logic [3:0] OP_UPD_FRONT = 4'd5;
  localparam logic [3:0] OP_UPD_LAST  = 4'd6;
  localparam logic [3:0] OP_UPD_AT    = 4'd7;
  localparam logic [3:0] OP_UPD_KEY   = 4'd8;
  localparam logic [3:0] OP_DEL_FRONT = 4'd9;
  localparam logic [3:0] OP_DEL_LAST  = 4'd10;
  localparam logic [3:0] OP_DEL_AT    = 4'd11;
  localparam logic [3:0] OP_DEL_KEY   = 4'd12;
  localparam logic [3:0] OP_SEARCH    = 4'd13;
  localparam logic [3:0] OP_READ      = 4'd14;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] item_value;
    logic [7:0]         position;
    logic signed [31:0] match_key;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [8:0]         entry_count;
  } rsp_t;

  // broadcast command to every cell of the chain
  typedef struct packed {
    logic ins;   // open a slot at the target, cells above take the left word
    logic del;   // close the target, cells from it up take the right word
    logic wr;    // overwrite the target
  } cell_cmd_t;

endpackage

### hw/rtl/ordered_list_engine_top.sv
// Ordered list engine top level: request control, cell chain and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_stall  | in_req  (op, value, position, key)
//  out     | output    | out_valid / out_stall| out_rsp (status, value, pos, count)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (descending_order)
//
// One request at a time. Position-based requests go from accept through flag and
// apply, then back to idle before the next accept. Key-based and sorted requests
// that hit also pass through scan, where the flag shifter in olist_scan steps to
// the first hit. A stalled result holds the engine in apply.
// Synchronous reset empties the list and clears descending_order; cell words
// are left as they are and are never read at or above the count.
module ordered_list_engine_top
  import olist_pkg::*;
#(
  parameter int CAPACITY   = OL_CAPACITY,
  parameter int DATA_WIDTH = OL_DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > 8) ? CW : 8) + 1;
  localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLAG  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  req_t          req;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          descending_order;
  logic          found;
  logic [DATA_WIDTH-1:0] rd_word;

  // Request words reduced to the storage width.
  logic signed [XW-1:0]  val_x;
  logic signed [XW-1:0]  key_x;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] key_word;

  assign val_x    = XW'(req.item_value);
  assign key_x    = XW'(req.match_key);
  assign new_word = val_x[DATA_WIDTH-1:0];
  assign key_word = key_x[DATA_WIDTH-1:0];

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending_order <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      descending_order <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= in_req;
    end
  end

  // Cell chain.
  logic [DATA_WIDTH-1:0] words     [CAPACITY];
  logic [DATA_WIDTH-1:0] read_words[CAPACITY];
  logic [CAPACITY-1:0]   match_vec;
  logic [CAPACITY-1:0]   order_vec;
  cell_cmd_t             cmd;
  logic [IW-1:0]         tgt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    olist_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CAPACITY  (CAPACITY),
      .INDEX     (i)
    ) u_cell (
      .clk             (clk),
      .cmd             (cmd),
      .tgt             (tgt),
      .new_word        (new_word),
      .key_word        (key_word),
      .position        (req.position),
      .count           (count),
      .descending_order(descending_order),
      .left_word       (left_w),
      .right_word      (right_w),
      .word            (words[i]),
      .match           (match_vec[i]),
      .order_hit       (order_vec[i]),
      .read_word       (read_words[i])
    );
  end

  // Pick the flag row the request scans: key matches or sorted-order hits.
  logic [CAPACITY-1:0]   flags;
  logic [DATA_WIDTH-1:0] read_or;
  logic                  use_order;

  assign use_order = (req.op == OP_INS_SORT);
  assign flags     = use_order ? order_vec : match_vec;

  always_comb begin
    read_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_or = read_or | read_words[i];
    end
  end

  logic          scan_hit;
  logic [IW-1:0] scan_idx;

  olist_scan #(
    .CAPACITY(CAPACITY)
  ) u_scan (
    .clk    (clk),
    .load   (state == S_FLAG),
    .advance((state == S_SCAN) && !scan_hit),
    .flags  (flags),
    .hit    (scan_hit),
    .idx    (scan_idx)
  );

  always_ff @(posedge clk) begin
    if (state == S_FLAG) begin
      found   <= |flags;
      rd_word <= read_or;
    end
  end

  // Decide status, target and cell command for the request.
  logic [LW-1:0]  pos_w;
  logic [LW-1:0]  cnt_w;
  logic [LW-1:0]  idx_w;
  logic [LW-1:0]  last_w;
  logic [LW-1:0]  slot;
  logic [1:0]     status;
  cell_cmd_t      act;
  logic           is_ins;
  logic           is_upd;
  logic           is_del;
  logic           commit;
  logic [XW-1:0]  rd_x;
  rsp_t           rsp_next;

  assign pos_w  = LW'(req.position);
  assign cnt_w  = LW'(count);
  assign idx_w  = LW'(scan_idx);
  assign last_w = cnt_w - LW'(1);
  assign rd_x   = XW'(rd_word);

  always_comb begin
    status = ST_OK;
    slot   = '0;
    is_ins = 1'b0;
    is_upd = 1'b0;
    is_del = 1'b0;
    unique case (req.op) inside
      OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      OP_INS_LAST: begin
        is_ins = 1'b1;
        slot   = cnt_w;
      end
      OP_INS_AT: begin
        is_ins = 1'b1;
        slot   = pos_w;
        if (pos_w > cnt_w) status = ST_RANGE;
      end
      OP_INS_KEY: begin
        is_ins = 1'b1;
        slot   = idx_w;
        if (!found) status = ST_MISSING;
      end
      OP_INS_SORT: begin
        is_ins = 1'b1;
        slot   = found ? idx_w : cnt_w;
      end
      OP_UPD_FRONT, OP_DEL_FRONT: begin
        is_upd = (req.op == OP_UPD_FRONT);
        is_del = (req.op == OP_DEL_FRONT);
        if (count == '0) status = ST_RANGE;
      end
      OP_UPD_LAST, OP_DEL_LAST: begin
        is_upd = (req.op == OP_UPD_LAST);
        is_del = (req.op == OP_DEL_LAST);
        slot   = last_w;
        if (count == '0) status = ST_RANGE;
      end
      OP_UPD_AT, OP_DEL_AT: begin
        is_upd = (req.op == OP_UPD_AT);
        is_del = (req.op == OP_DEL_AT);
        slot   = pos_w;
        if (pos_w >= cnt_w) status = ST_RANGE;
      end
      OP_UPD_KEY, OP_DEL_KEY, OP_SEARCH: begin
        is_upd = (req.op == OP_UPD_KEY);
        is_del = (req.op == OP_DEL_KEY);
        slot   = idx_w;
        if (!found) status = ST_MISSING;
      end
      OP_READ: begin
        if (pos_w >= cnt_w) status = ST_RANGE;
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
    // fullness is checked after range and key lookup
    if (is_ins && (status == ST_OK) && (count == CW'(CAPACITY))) status = ST_FULL;
  end

  assign commit = (state == S_APPLY) && (!out_valid || !out_stall);
  assign tgt    = slot[IW-1:0];

  always_comb begin
    act.ins = is_ins && (status == ST_OK);
    act.del = is_del && (status == ST_OK);
    act.wr  = is_upd && (status == ST_OK);
    cmd     = commit ? act : '0;
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) count_next = count + CW'(1);
    if (cmd.del) count_next = count - CW'(1);
  end

  always_comb begin
    rsp_next.status         = status;
    rsp_next.read_value     = '0;
    rsp_next.found_position = '0;
    rsp_next.entry_count    = 9'(count_next);
    if ((req.op == OP_READ) && (status == ST_OK)) rsp_next.read_value = rd_x[31:0];
    if ((req.op == OP_SEARCH) && (status == ST_OK)) rsp_next.found_position = idx_w[7:0];
  end

  // Sequencer: flag the cells, scan to the first hit when needed, then apply.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_FLAG;
      end
      S_FLAG: begin
        if ((req.op == OP_INS_KEY || req.op == OP_INS_SORT || req.op == OP_UPD_KEY ||
             req.op == OP_DEL_KEY || req.op == OP_SEARCH) && (|flags)) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_SCAN: begin
        if (scan_hit) state_next = S_APPLY;
      end
      S_APPLY: begin
        if (commit) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Result register: hold until taken, load on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    commit |=> (out_rsp.entry_count == 9'(count)))
    else $error("reported entry count differs from list count");

  a_scan_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(scan_idx) < count))
    else $error("scan ran past the end of the list");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    (commit && cmd.ins) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_cmd_only_apply: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins || cmd.del || cmd.wr) |-> (state == S_APPLY) && $onehot({cmd.ins, cmd.del, cmd.wr}))
    else $error("cell command outside apply or not unique");
`endif

endmodule

### hw/rtl/olist_cell.sv
// One list cell: holds one word, shifts with its neighbors, flags key and order hits.
module olist_cell
  import olist_pkg::*;
#(
  parameter int DATA_WIDTH = OL_DATA_WIDTH,
  parameter int CAPACITY   = OL_CAPACITY,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [$clog2(CAPACITY)-1:0]   tgt,
  input  logic [DATA_WIDTH-1:0] new_word,
  input  logic [DATA_WIDTH-1:0] key_word,
  input  logic [7:0]            position,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic                  descending_order,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic                  match,
  output logic                  order_hit,
  output logic [DATA_WIDTH-1:0] read_word
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic in_list;
  logic sel;

  assign in_list = (CW'(INDEX) < count);
  assign sel     = (LW'(INDEX) == LW'(position)) && in_list;

  assign match     = in_list && (word == key_word);
  assign order_hit = in_list && (descending_order ? ($signed(word) <= $signed(new_word))
                                                  : ($signed(word) >= $signed(new_word)));
  assign read_word = sel ? word : '0;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (MY_IDX > tgt) begin
        word <= left_word;
      end else if (MY_IDX == tgt) begin
        word <= new_word;
      end
    end else if (cmd.del) begin
      if (MY_IDX >= tgt) begin
        word <= right_word;
      end
    end else if (cmd.wr) begin
      if (MY_IDX == tgt) begin
        word <= new_word;
      end
    end
  end

endmodule

### hw/rtl/olist_scan.sv
// First-hit finder: shifts the cell flag row toward cell 0 and counts steps.
module olist_scan
  import olist_pkg::*;
#(
  parameter int CAPACITY = OL_CAPACITY
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        advance,
  input  logic [CAPACITY-1:0]         flags,
  output logic                        hit,
  output logic [$clog2(CAPACITY)-1:0] idx
);

  localparam int IW = $clog2(CAPACITY);

  logic [CAPACITY-1:0] vec;

  assign hit = vec[0];

  always_ff @(posedge clk) begin
    if (load) begin
      vec <= flags;
      idx <= '0;
    end else if (advance) begin
      vec <= {1'b0, vec[CAPACITY-1:1]};
      idx <= idx + IW'(1);
    end
  end

endmodule
